// ----- rtl/core/gyro_aided_differential_odometry_macros.svh -----
// Assertion macros shared by the odometry block.
`ifndef GYRO_AIDED_DIFFERENTIAL_ODOMETRY_MACROS_SVH
`define GYRO_AIDED_DIFFERENTIAL_ODOMETRY_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GADO_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GADO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/gado_pkg.sv -----
// Shared types, constants and tables for the gyro-aided odometry block.
package gado_pkg;

   localparam int TRIG_ITERS_DEFAULT = 16;
   localparam int MAX_TABLE          = 24;
   localparam int ITER_W             = $clog2(MAX_TABLE);

   localparam logic signed [32:0] CORDIC_START = 33'sd652032874;

   // Configuration register indexes
   localparam logic [1:0] REG_LEFT_SCALE  = 2'd0;
   localparam logic [1:0] REG_RIGHT_SCALE = 2'd1;
   localparam logic [1:0] REG_START_X     = 2'd2;
   localparam logic [1:0] REG_START_Y     = 2'd3;

   typedef enum logic [1:0] {
      CMD_UPDATE    = 2'd0,
      CMD_REBASE    = 2'd1,
      CMD_LOAD_POSE = 2'd2,
      CMD_UNUSED    = 2'd3
   } gado_command_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_REF,
      OP_REBASE,
      OP_LOAD_POSE,
      OP_MUL_L,
      OP_MUL_R,
      OP_SUM,
      OP_CORDIC_STEP,
      OP_ROTATE,
      OP_PP_HI,
      OP_PP_LO,
      OP_ROUND,
      OP_APPLY,
      OP_FINISH,
      OP_PUBLISH
   } gado_op_type;

   typedef struct packed {
      gado_op_type       op;
      logic              axis;   // 0 x, 1 y
      logic [ITER_W-1:0] iter;
   } gado_cmd_type;

   typedef struct packed {
      gado_command_type command;
      logic             rebase_pending;
   } gado_stat_type;

   // Arctangent of 2^-i as a binary angle scaled to 2^32 per turn
   function automatic logic signed [31:0] atan_entry(input logic [ITER_W-1:0] idx);
      logic signed [31:0] v;
      case (idx)
         5'd0:    v = 32'sd536870912;
         5'd1:    v = 32'sd316933406;
         5'd2:    v = 32'sd167458907;
         5'd3:    v = 32'sd85004756;
         5'd4:    v = 32'sd42667331;
         5'd5:    v = 32'sd21354465;
         5'd6:    v = 32'sd10679838;
         5'd7:    v = 32'sd5340245;
         5'd8:    v = 32'sd2670163;
         5'd9:    v = 32'sd1335087;
         5'd10:   v = 32'sd667544;
         5'd11:   v = 32'sd333772;
         5'd12:   v = 32'sd166886;
         5'd13:   v = 32'sd83443;
         5'd14:   v = 32'sd41722;
         5'd15:   v = 32'sd20861;
         5'd16:   v = 32'sd10430;
         5'd17:   v = 32'sd5215;
         5'd18:   v = 32'sd2608;
         5'd19:   v = 32'sd1304;
         5'd20:   v = 32'sd652;
         5'd21:   v = 32'sd326;
         5'd22:   v = 32'sd163;
         5'd23:   v = 32'sd81;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/core/gado_datapath.sv -----
// Datapath of the odometry block: state, shared multiplier, CORDIC and output register.
module gado_datapath
   import gado_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  gado_cmd_type        cmd,
   output gado_stat_type       stat,
   input  logic [1:0]          req_command,
   input  logic signed [31:0]  req_left_ticks,
   input  logic signed [31:0]  req_right_ticks,
   input  logic [15:0]         req_gyro_heading,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_data,
   output logic signed [31:0]  rsp_pos_x,
   output logic signed [31:0]  rsp_pos_y,
   output logic [15:0]         rsp_heading
);

   localparam logic signed [52:0] POS_MAX = 53'sd2147483647;
   localparam logic signed [52:0] NEG_MIN = -53'sd2147483648;

   // Configuration
   logic [23:0]        left_scale_ff, right_scale_ff;
   logic signed [31:0] start_x_ff, start_y_ff;

   // Captured request
   logic [1:0]         cmd_ff;
   logic signed [31:0] lt_ff, rt_ff;
   logic [15:0]        g_ff;

   // Odometry state
   logic signed [31:0] last_left_ff, last_right_ff, cur_x_ff, cur_y_ff;
   logic [15:0]        heading_ref_ff, cur_heading_ff;
   logic               rebase_pending_ff;

   // Working registers
   logic signed [65:0] prod_ff;
   logic signed [57:0] acc_ff, sum_ff;
   logic [56:0]        a_mag_ff, hi_ff;
   logic [31:0]        b_x_ff, b_y_ff;
   logic               neg_x_ff, neg_y_ff;
   logic signed [32:0] x_ff, y_ff;
   logic signed [31:0] z_ff;
   logic [1:0]         quad_ff;
   logic signed [51:0] step_ff;

   logic signed [31:0] rsp_x_ff, rsp_y_ff;
   logic [15:0]        rsp_heading_ff;

   logic signed [32:0] d_left, d_right, mul_a, mul_b;
   logic [15:0]        sh;
   logic signed [14:0] z_off;
   logic signed [32:0] xs, ys, c_val, s_val, c_mag, s_mag;
   logic signed [57:0] sum_mag;
   logic [89:0]        round_sum;
   logic [50:0]        mag;
   logic signed [31:0] cur_sel;
   logic signed [52:0] apply_sum;
   logic signed [31:0] apply_sat;

   assign csr_ready = 1'b1;

   assign stat.command        = gado_command_type'(cmd_ff);
   assign stat.rebase_pending = rebase_pending_ff;

   assign d_left  = {lt_ff[31], lt_ff} - {last_left_ff[31], last_left_ff};
   assign d_right = {rt_ff[31], rt_ff} - {last_right_ff[31], last_right_ff};

   // Shift the angle so each quadrant is centred on zero
   assign sh    = g_ff + 16'h2000;
   assign z_off = $signed({1'b0, sh[13:0]}) - 15'sh2000;

   assign xs = x_ff >>> cmd.iter;
   assign ys = y_ff >>> cmd.iter;

   always_comb begin
      case (quad_ff)
         2'd0:    begin c_val = x_ff;  s_val = y_ff;  end
         2'd1:    begin c_val = -y_ff; s_val = x_ff;  end
         2'd2:    begin c_val = -x_ff; s_val = -y_ff; end
         default: begin c_val = y_ff;  s_val = -x_ff; end
      endcase
   end

   assign c_mag   = c_val[32] ? -c_val : c_val;
   assign s_mag   = s_val[32] ? -s_val : s_val;
   assign sum_mag = sum_ff[57] ? -sum_ff : sum_ff;

   // Operand selection for the shared multiplier
   always_comb begin
      case (cmd.op)
         OP_MUL_L: begin mul_a = d_left;  mul_b = $signed({9'b0, left_scale_ff});  end
         OP_MUL_R: begin mul_a = d_right; mul_b = $signed({9'b0, right_scale_ff}); end
         OP_PP_HI: begin
            mul_a = $signed({8'b0, a_mag_ff[56:32]});
            mul_b = $signed({1'b0, (cmd.axis ? b_y_ff : b_x_ff)});
         end
         default: begin
            mul_a = $signed({1'b0, a_mag_ff[31:0]});
            mul_b = $signed({1'b0, (cmd.axis ? b_y_ff : b_x_ff)});
         end
      endcase
   end

   // Round half up on the magnitude: (hi * 2^32 + lo + 2^38) >> 39
   assign round_sum = {1'b0, hi_ff, 32'b0} + {26'b0, prod_ff[63:0]} + (90'd1 << 38);
   assign mag       = round_sum[89:39];

   assign cur_sel   = cmd.axis ? cur_y_ff : cur_x_ff;
   assign apply_sum = {{21{cur_sel[31]}}, cur_sel} + {step_ff[51], step_ff};

   always_comb begin
      if (apply_sum > POS_MAX) begin
         apply_sat = 32'sh7FFFFFFF;
      end else if (apply_sum < NEG_MIN) begin
         apply_sat = 32'sh80000000;
      end else begin
         apply_sat = apply_sum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_scale_ff     <= '0;
         right_scale_ff    <= '0;
         start_x_ff        <= '0;
         start_y_ff        <= '0;
         last_left_ff      <= '0;
         last_right_ff     <= '0;
         cur_x_ff          <= '0;
         cur_y_ff          <= '0;
         heading_ref_ff    <= '0;
         cur_heading_ff    <= '0;
         rebase_pending_ff <= 1'b1;
         cmd_ff            <= CMD_UNUSED;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               REG_LEFT_SCALE:  left_scale_ff  <= csr_data[23:0];
               REG_RIGHT_SCALE: right_scale_ff <= csr_data[23:0];
               REG_START_X:     start_x_ff     <= csr_data;
               REG_START_Y:     start_y_ff     <= csr_data;
            endcase
         end
         case (cmd.op)
            OP_CAPTURE: begin
               cmd_ff <= req_command;
               lt_ff  <= req_left_ticks;
               rt_ff  <= req_right_ticks;
               g_ff   <= req_gyro_heading;
            end
            OP_REF: begin
               heading_ref_ff    <= g_ff;
               rebase_pending_ff <= 1'b0;
            end
            OP_REBASE: begin
               last_left_ff  <= lt_ff;
               last_right_ff <= rt_ff;
            end
            OP_LOAD_POSE: begin
               cur_x_ff          <= start_x_ff;
               cur_y_ff          <= start_y_ff;
               cur_heading_ff    <= '0;
               rebase_pending_ff <= 1'b1;
            end
            OP_MUL_L: prod_ff <= mul_a * mul_b;
            OP_MUL_R: begin
               acc_ff  <= prod_ff[57:0];
               prod_ff <= mul_a * mul_b;
            end
            OP_SUM: begin
               sum_ff  <= acc_ff + prod_ff[57:0];
               x_ff    <= CORDIC_START;
               y_ff    <= '0;
               z_ff    <= {z_off[14], z_off, 16'b0};
               quad_ff <= sh[15:14];
            end
            OP_CORDIC_STEP: begin
               if (!z_ff[31]) begin
                  x_ff <= x_ff - ys;
                  y_ff <= y_ff + xs;
                  z_ff <= z_ff - atan_entry(cmd.iter);
               end else begin
                  x_ff <= x_ff + ys;
                  y_ff <= y_ff - xs;
                  z_ff <= z_ff + atan_entry(cmd.iter);
               end
            end
            OP_ROTATE: begin
               a_mag_ff <= sum_mag[56:0];
               b_x_ff   <= c_mag[31:0];
               b_y_ff   <= s_mag[31:0];
               neg_x_ff <= sum_ff[57] ^ c_val[32];
               neg_y_ff <= sum_ff[57] ^ s_val[32];
            end
            OP_PP_HI: prod_ff <= mul_a * mul_b;
            OP_PP_LO: begin
               hi_ff   <= prod_ff[56:0];
               prod_ff <= mul_a * mul_b;
            end
            OP_ROUND: begin
               if (cmd.axis ? neg_y_ff : neg_x_ff) begin
                  step_ff <= -$signed({1'b0, mag});
               end else begin
                  step_ff <= $signed({1'b0, mag});
               end
            end
            OP_APPLY: begin
               if (cmd.axis) begin
                  cur_y_ff <= apply_sat;
               end else begin
                  cur_x_ff <= apply_sat;
               end
            end
            OP_FINISH: begin
               if (cmd_ff == CMD_UPDATE) begin
                  last_left_ff   <= lt_ff;
                  last_right_ff  <= rt_ff;
                  cur_heading_ff <= g_ff - heading_ref_ff;
               end
            end
            default: ;
         endcase
      end
   end

   // Result register, loaded when the controller publishes
   always_ff @(posedge clock) begin
      if (cmd.op == OP_PUBLISH) begin
         rsp_x_ff       <= cur_x_ff;
         rsp_y_ff       <= cur_y_ff;
         rsp_heading_ff <= cur_heading_ff;
      end
   end

   assign rsp_pos_x   = rsp_x_ff;
   assign rsp_pos_y   = rsp_y_ff;
   assign rsp_heading = rsp_heading_ff;

endmodule

// ----- rtl/core/gado_ctrl.sv -----
// Controller of the odometry block: sequences the datapath one request at a time.
module gado_ctrl
   import gado_pkg::*;
#(
   parameter int TRIG_ITERS = TRIG_ITERS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  gado_stat_type stat,
   output gado_cmd_type  cmd
);

   localparam int ITERS_EFF = (TRIG_ITERS < MAX_TABLE) ? TRIG_ITERS : MAX_TABLE;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_MUL_R,
      S_SUM,
      S_CORDIC,
      S_ROTATE,
      S_PP_HI,
      S_PP_LO,
      S_ROUND,
      S_APPLY,
      S_FINISH,
      S_PUBLISH
   } state_type;

   state_type         state_ff, state_in;
   logic              axis_ff, axis_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      iter_in  = iter_ff;
      cmd.op   = OP_NONE;
      cmd.axis = axis_ff;
      cmd.iter = iter_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = OP_CAPTURE;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_FINISH;
            unique case (stat.command)
               CMD_UPDATE: begin
                  if (stat.rebase_pending) begin
                     cmd.op = OP_REF;
                  end else begin
                     cmd.op   = OP_MUL_L;
                     state_in = S_MUL_R;
                  end
               end
               CMD_REBASE:    cmd.op = OP_REBASE;
               CMD_LOAD_POSE: cmd.op = OP_LOAD_POSE;
               CMD_UNUSED:    cmd.op = OP_NONE;
            endcase
         end
         S_MUL_R: begin
            cmd.op   = OP_MUL_R;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.op   = OP_SUM;
            iter_in  = '0;
            state_in = S_CORDIC;
         end
         S_CORDIC: begin
            cmd.op = OP_CORDIC_STEP;
            if (iter_ff == ITER_W'(ITERS_EFF - 1)) begin
               state_in = S_ROTATE;
            end else begin
               iter_in = iter_ff + 1'b1;
            end
         end
         S_ROTATE: begin
            cmd.op   = OP_ROTATE;
            axis_in  = 1'b0;
            state_in = S_PP_HI;
         end
         S_PP_HI: begin
            cmd.op   = OP_PP_HI;
            state_in = S_PP_LO;
         end
         S_PP_LO: begin
            cmd.op   = OP_PP_LO;
            state_in = S_ROUND;
         end
         S_ROUND: begin
            cmd.op   = OP_ROUND;
            state_in = S_APPLY;
         end
         S_APPLY: begin
            cmd.op = OP_APPLY;
            if (axis_ff) begin
               state_in = S_FINISH;
            end else begin
               axis_in  = 1'b1;
               state_in = S_PP_HI;
            end
         end
         S_FINISH: begin
            cmd.op   = OP_FINISH;
            state_in = S_PUBLISH;
         end
         S_PUBLISH: begin
            // hold until the result register is free or being emptied
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.op   = OP_PUBLISH;
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      if (cmd.op == OP_PUBLISH) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         axis_ff      <= 1'b0;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- rtl/core/gyro_aided_differential_odometry.sv -----
// Top level of the gyro-aided differential-drive odometry block.
//
// Requests arrive on the req_ stream: req_tuser carries the command (update,
// encoder re-base, pose load), req_tdata the absolute left and right tick
// counts and the gyro heading. Every request yields exactly one response on
// the rsp_ stream carrying the position and relative heading after the request.
// Registers (left_scale, right_scale, start_x, start_y) are written on the
// csr_ channel, which is always ready; write them only while the block is idle.
// One request is processed at a time. An update that moves the robot is
// paced by the CORDIC, which resolves one iteration per cycle, and by the one
// shared multiplier, used for both wheel scalings and for the high and low
// partial products of each axis. Re-base, pose load, the baseline-capturing
// first update and the unused code pass from decode to finish and publish.
// With the receiver ready, the next request is taken as the response appears.
// A response waits in the output register while the receiver stalls; the
// next request is accepted meanwhile, and its response holds until the
// register is free. Reset clears the pose, baseline and registers to zero,
// arms the baseline capture and empties the output register.
`include "gyro_aided_differential_odometry_macros.svh"

module gyro_aided_differential_odometry
   import gado_pkg::*;
#(
   parameter int TRIG_ITERS = TRIG_ITERS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // command
   input  logic [79:0] req_tdata,   // left_ticks, right_ticks, gyro_heading
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // pos_x, pos_y, heading
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int ITERS_EFF = (TRIG_ITERS < MAX_TABLE) ? TRIG_ITERS : MAX_TABLE;

   gado_cmd_type       ctl_cmd;
   gado_stat_type      dp_stat;
   logic signed [31:0] pos_x, pos_y;
   logic [15:0]        heading;
   logic               req_fire, publish_op, slot_free, step_op, iter_ok, capture_op;

   gado_ctrl #(
      .TRIG_ITERS (TRIG_ITERS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (dp_stat),
      .cmd        (ctl_cmd)
   );

   gado_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (ctl_cmd),
      .stat             (dp_stat),
      .req_command      (req_tuser),
      .req_left_ticks   (req_tdata[31:0]),
      .req_right_ticks  (req_tdata[63:32]),
      .req_gyro_heading (req_tdata[79:64]),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_pos_x        (pos_x),
      .rsp_pos_y        (pos_y),
      .rsp_heading      (heading)
   );

   assign rsp_tdata = {heading, pos_y, pos_x};

   assign req_fire   = req_tvalid && req_tready;
   assign publish_op = (ctl_cmd.op == OP_PUBLISH);
   assign slot_free  = !rsp_tvalid || rsp_tready;
   assign step_op    = (ctl_cmd.op == OP_CORDIC_STEP);
   assign iter_ok    = (ctl_cmd.iter < ITER_W'(ITERS_EFF));
   assign capture_op = (ctl_cmd.op == OP_CAPTURE);

   `GADO_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_tready, "accepted while busy")
   `GADO_ASSERT_SAME(a_publish_slot_free, clock, reset, publish_op, slot_free, "response overwritten")
   `GADO_ASSERT_SAME(a_iter_in_range, clock, reset, step_op, iter_ok, "iteration out of range")
   `GADO_ASSERT_SAME(a_capture_when_ready, clock, reset, capture_op, req_fire, "stray capture")

endmodule
